### design/spg_pkg.sv
// ============================================================================
// spg_pkg - shared widths, codes and types for the segment/point geometry unit
// Coordinate and fraction widths, the widths that follow from them, the mode
// codes and the structs passed between the pipeline sections.
// ============================================================================
package spg_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // Derived widths
    localparam int CW   = COORD_BITS;              // coordinate
    localparam int DW   = CW + 1;                  // coordinate difference
    localparam int PW   = 2 * DW;                  // product of two differences
    localparam int XW   = PW + 1;                  // cross product, signed
    localparam int MW   = 2 * CW + 1;              // cross magnitude, |AB|^2, divisor
    localparam int QB   = 2 * (CW + FRAC_BITS + 1); // divider quotient bits
    localparam int RB   = CW + FRAC_BITS + 1;      // root bits, distance width
    localparam int NW   = QB + MW;                 // divider dividend width
    localparam int XB   = CW + FRAC_BITS;          // crossing coordinate width
    localparam int MX0W = CW + MW + 1;             // P0 * den
    localparam int MX1W = DW + MW + 1;             // (P1 - P0) * tn
    localparam int SW   = DW + MW + 2;             // crossing numerator
    localparam int SBD  = QB + RB;                 // sideband delay to the output

    typedef enum logic [1:0] {
        MODE_SIDE  = 2'd0,
        MODE_DIST  = 2'd1,
        MODE_CROSS = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [1:0] SIDE_LEFT  = 2'b01;
    localparam logic [1:0] SIDE_ON    = 2'b00;
    localparam logic [1:0] SIDE_RIGHT = 2'b11;

    // Per-item control that runs alongside the dividers
    typedef struct packed {
        t_mode      mode;
        logic [1:0] side;
        logic       hit;
        logic       neg_x;
        logic       neg_y;
    } t_side;

    // Front-end result: control plus the operands of both divider lanes
    typedef struct packed {
        t_side          ctl;
        logic [NW-1:0]  dvd0;
        logic [MW-1:0]  dvs0;
        logic [NW-1:0]  dvd1;
        logic [MW-1:0]  dvs1;
    } t_front;

    // One finished result item
    typedef struct packed {
        logic [1:0]    side;
        logic [RB-1:0] dist_q8;
        logic          hit;
        logic [XB-1:0] cx;
        logic [XB-1:0] cy;
    } t_res;

endpackage

### design/spg_front.sv
// ============================================================================
// spg_front - six-stage arithmetic front end
// Differences, cross products, sign handling and the operands of the two
// divider lanes. All stages advance together on i_en.
// ============================================================================
module spg_front import spg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [1:0]           i_mode,
    input  logic signed [CW-1:0] i_seg_a_x,
    input  logic signed [CW-1:0] i_seg_a_y,
    input  logic signed [CW-1:0] i_seg_b_x,
    input  logic signed [CW-1:0] i_seg_b_y,
    input  logic signed [CW-1:0] i_pt_x,
    input  logic signed [CW-1:0] i_pt_y,
    input  logic signed [CW-1:0] i_pt2_x,
    input  logic signed [CW-1:0] i_pt2_y,
    output logic                 o_valid,
    output t_front               o_front
);

    // valid bits of the six stages
    logic [5:0] r_v;

    // stage 1: differences
    t_mode               r1_mode;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_ex, r1_ey, r1_wx, r1_wy;
    logic signed [CW-1:0] r1_px, r1_py, r1_qx, r1_qy;
    logic                 r1_eq;

    // stage 2: products
    t_mode                r2_mode;
    logic signed [PW-1:0] r2_eydx, r2_exdy, r2_wxdy, r2_wydx, r2_eywx, r2_exwy;
    logic signed [PW-1:0] r2_dxdx, r2_dydy, r2_exex, r2_eyey;
    logic signed [DW-1:0] r2_wx, r2_wy;
    logic signed [CW-1:0] r2_px, r2_py, r2_qx, r2_qy;
    logic                 r2_eq;

    // stage 3: cross sums
    t_mode                r3_mode;
    logic signed [XW-1:0] r3_c, r3_den, r3_sn;
    logic [MW-1:0]        r3_len2, r3_e2;
    logic signed [DW-1:0] r3_wx, r3_wy;
    logic signed [CW-1:0] r3_px, r3_py, r3_qx, r3_qy;
    logic                 r3_eq;

    // stage 4: signs and range tests
    t_mode                r4_mode;
    logic [1:0]           r4_side;
    logic                 r4_hit, r4_par, r4_degen;
    logic [MW-1:0]        r4_cabs, r4_tn, r4_den, r4_len2, r4_e2;
    logic signed [DW-1:0] r4_wx, r4_wy;
    logic signed [CW-1:0] r4_px, r4_py, r4_qx, r4_qy;

    // stage 5: wide products
    t_mode                  r5_mode;
    logic [1:0]             r5_side;
    logic                   r5_hit, r5_par, r5_degen;
    logic [2*MW-1:0]        r5_csq;
    logic signed [MX0W-1:0] r5_mx0, r5_my0;
    logic signed [MX1W-1:0] r5_mx1, r5_my1;
    logic [MW-1:0]          r5_den, r5_len2, r5_e2;
    logic signed [CW-1:0]   r5_qx, r5_qy;

    // stage 6: divider operands
    t_front r6_front;

    // stage 4 combinational terms
    logic signed [XW-1:0] n_den, n_tn, n_sn, n_cabs;
    logic                 n_hit_x;

    // stage 6 combinational terms
    logic signed [SW-1:0] n_sum_x, n_sum_y;
    logic [SW-1:0]        n_abs_x, n_abs_y;
    logic [CW-1:0]        n_aqx, n_aqy;
    t_front               n_front;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= t_mode'(i_mode);
            r1_dx   <= DW'(i_seg_b_x) - DW'(i_seg_a_x);
            r1_dy   <= DW'(i_seg_b_y) - DW'(i_seg_a_y);
            r1_ex   <= DW'(i_pt_x) - DW'(i_seg_a_x);
            r1_ey   <= DW'(i_pt_y) - DW'(i_seg_a_y);
            r1_wx   <= DW'(i_pt2_x) - DW'(i_pt_x);
            r1_wy   <= DW'(i_pt2_y) - DW'(i_pt_y);
            r1_px   <= i_pt_x;
            r1_py   <= i_pt_y;
            r1_qx   <= i_pt2_x;
            r1_qy   <= i_pt2_y;
            r1_eq   <= ((i_seg_a_x == i_pt_x) && (i_seg_a_y == i_pt_y)) ||
                       ((i_seg_a_x == i_pt2_x) && (i_seg_a_y == i_pt2_y));
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mode <= r1_mode;
            r2_eydx <= r1_ey * r1_dx;
            r2_exdy <= r1_ex * r1_dy;
            r2_wxdy <= r1_wx * r1_dy;
            r2_wydx <= r1_wy * r1_dx;
            r2_eywx <= r1_ey * r1_wx;
            r2_exwy <= r1_ex * r1_wy;
            r2_dxdx <= r1_dx * r1_dx;
            r2_dydy <= r1_dy * r1_dy;
            r2_exex <= r1_ex * r1_ex;
            r2_eyey <= r1_ey * r1_ey;
            r2_wx   <= r1_wx;
            r2_wy   <= r1_wy;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_qx   <= r1_qx;
            r2_qy   <= r1_qy;
            r2_eq   <= r1_eq;
        end
    end

    // stage 3: c (also tn), den, sn and squared lengths
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mode <= r2_mode;
            r3_c    <= XW'(r2_eydx) - XW'(r2_exdy);
            r3_den  <= XW'(r2_wxdy) - XW'(r2_wydx);
            r3_sn   <= XW'(r2_eywx) - XW'(r2_exwy);
            r3_len2 <= MW'(r2_dxdx) + MW'(r2_dydy);
            r3_e2   <= MW'(r2_exex) + MW'(r2_eyey);
            r3_wx   <= r2_wx;
            r3_wy   <= r2_wy;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_qx   <= r2_qx;
            r3_qy   <= r2_qy;
            r3_eq   <= r2_eq;
        end
    end

    // stage 4: make den positive and test both parameters against [0, den]
    always_comb begin
        n_den   = r3_den[XW-1] ? -r3_den : r3_den;
        n_tn    = r3_den[XW-1] ? -r3_c   : r3_c;
        n_sn    = r3_den[XW-1] ? -r3_sn  : r3_sn;
        n_cabs  = r3_c[XW-1]   ? -r3_c   : r3_c;
        n_hit_x = (r3_den != '0) && !n_tn[XW-1] && (n_tn <= n_den) &&
                  !n_sn[XW-1] && (n_sn <= n_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mode  <= r3_mode;
            if (r3_mode != MODE_SIDE) begin
                r4_side <= SIDE_ON;
            end else if (r3_c[XW-1]) begin
                r4_side <= SIDE_RIGHT;
            end else if (r3_c != '0) begin
                r4_side <= SIDE_LEFT;
            end else begin
                r4_side <= SIDE_ON;
            end
            r4_par   <= (r3_den == '0) && r3_eq;
            r4_hit   <= (r3_mode == MODE_CROSS) &&
                        (n_hit_x || ((r3_den == '0) && r3_eq));
            r4_degen <= (r3_len2 == '0);
            r4_cabs  <= n_cabs[MW-1:0];
            r4_tn    <= n_tn[MW-1:0];
            r4_den   <= n_den[MW-1:0];
            r4_len2  <= r3_len2;
            r4_e2    <= r3_e2;
            r4_wx    <= r3_wx;
            r4_wy    <= r3_wy;
            r4_px    <= r3_px;
            r4_py    <= r3_py;
            r4_qx    <= r3_qx;
            r4_qy    <= r3_qy;
        end
    end

    // stage 5: c^2 and the crossing numerator terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_mode  <= r4_mode;
            r5_side  <= r4_side;
            r5_hit   <= r4_hit;
            r5_par   <= r4_par;
            r5_degen <= r4_degen;
            r5_csq   <= r4_cabs * r4_cabs;
            r5_mx0   <= r4_px * signed'({1'b0, r4_den});
            r5_my0   <= r4_py * signed'({1'b0, r4_den});
            r5_mx1   <= r4_wx * signed'({1'b0, r4_tn});
            r5_my1   <= r4_wy * signed'({1'b0, r4_tn});
            r5_den   <= r4_den;
            r5_len2  <= r4_len2;
            r5_e2    <= r4_e2;
            r5_qx    <= r4_qx;
            r5_qy    <= r4_qy;
        end
    end

    // stage 6: pick the divider operands for the mode
    always_comb begin
        n_sum_x = SW'(r5_mx0) + SW'(r5_mx1);
        n_sum_y = SW'(r5_my0) + SW'(r5_my1);
        n_abs_x = n_sum_x[SW-1] ? SW'(-n_sum_x) : SW'(n_sum_x);
        n_abs_y = n_sum_y[SW-1] ? SW'(-n_sum_y) : SW'(n_sum_y);
        n_aqx   = r5_qx[CW-1] ? CW'(-r5_qx) : CW'(r5_qx);
        n_aqy   = r5_qy[CW-1] ? CW'(-r5_qy) : CW'(r5_qy);

        n_front           = '0;
        n_front.ctl.mode  = r5_mode;
        n_front.ctl.side  = r5_side;
        n_front.ctl.hit   = r5_hit;
        n_front.dvs0      = MW'(1);
        n_front.dvs1      = MW'(1);
        case (r5_mode)
            MODE_DIST: begin
                if (r5_degen) begin
                    n_front.dvd0 = NW'(r5_e2) << (2 * FRAC_BITS);
                end else begin
                    n_front.dvd0 = NW'(r5_csq) << (2 * FRAC_BITS);
                    n_front.dvs0 = r5_len2;
                end
            end
            MODE_CROSS: begin
                if (r5_par) begin
                    // parallel with a shared end point: the crossing is P1
                    n_front.dvd0      = NW'(n_aqx) << FRAC_BITS;
                    n_front.dvd1      = NW'(n_aqy) << FRAC_BITS;
                    n_front.ctl.neg_x = r5_qx[CW-1];
                    n_front.ctl.neg_y = r5_qy[CW-1];
                end else if (r5_hit) begin
                    n_front.dvd0      = NW'(n_abs_x) << FRAC_BITS;
                    n_front.dvd1      = NW'(n_abs_y) << FRAC_BITS;
                    n_front.dvs0      = r5_den;
                    n_front.dvs1      = r5_den;
                    n_front.ctl.neg_x = n_sum_x[SW-1];
                    n_front.ctl.neg_y = n_sum_y[SW-1];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_front <= n_front;
        end
    end

    assign o_valid = r_v[5];
    assign o_front = r6_front;

endmodule

### design/spg_div.sv
// ============================================================================
// spg_div - pipelined restoring divider
// One quotient bit per stage. The upper part of the dividend must already be
// below the divisor, which holds for every operand the front end builds.
// ============================================================================
module spg_div import spg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_dividend,
    input  logic [MW-1:0] i_divisor,
    output logic [QB-1:0] o_quotient
);

    logic [MW-1:0] r_rem [QB];
    logic [QB-1:0] r_low [QB];
    logic [MW-1:0] r_dvs [QB];
    logic [QB-1:0] r_quo [QB];

    logic [MW-1:0] n_rem [QB];
    logic [QB-1:0] n_low [QB];
    logic [MW-1:0] n_dvs [QB];
    logic [QB-1:0] n_quo [QB];

    // one trial subtract per stage
    always_comb begin
        logic [MW-1:0] rem_in;
        logic [QB-1:0] low_in;
        logic [MW-1:0] dvs_in;
        logic [QB-1:0] quo_in;
        logic [MW:0]   trial;
        logic          take;
        for (int k = 0; k < QB; k++) begin
            if (k == 0) begin
                rem_in = i_dividend[NW-1:QB];
                low_in = i_dividend[QB-1:0];
                dvs_in = i_divisor;
                quo_in = '0;
            end else begin
                rem_in = r_rem[k-1];
                low_in = r_low[k-1];
                dvs_in = r_dvs[k-1];
                quo_in = r_quo[k-1];
            end
            trial    = {rem_in, low_in[QB-1]};
            take     = (trial >= {1'b0, dvs_in});
            n_rem[k] = take ? MW'(trial - {1'b0, dvs_in}) : trial[MW-1:0];
            n_low[k] = {low_in[QB-2:0], 1'b0};
            n_dvs[k] = dvs_in;
            n_quo[k] = {quo_in[QB-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_dvs[k] <= n_dvs[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quotient = r_quo[QB-1];

endmodule

### design/spg_isqrt.sv
// ============================================================================
// spg_isqrt - pipelined integer square root
// Digit-by-digit method, two radicand bits and one root bit per stage;
// gives the floor of the square root.
// ============================================================================
module spg_isqrt import spg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [QB-1:0] i_radicand,
    output logic [RB-1:0] o_root
);

    logic [QB-1:0] r_rad  [RB];
    logic [RB:0]   r_rem  [RB];
    logic [RB-1:0] r_root [RB];

    logic [QB-1:0] n_rad  [RB];
    logic [RB:0]   n_rem  [RB];
    logic [RB-1:0] n_root [RB];

    // remainder stays at most twice the partial root
    always_comb begin
        logic [QB-1:0] rad_in;
        logic [RB:0]   rem_in;
        logic [RB-1:0] root_in;
        logic [RB+2:0] cur;
        logic [RB+2:0] trial;
        logic          take;
        for (int k = 0; k < RB; k++) begin
            if (k == 0) begin
                rad_in  = i_radicand;
                rem_in  = '0;
                root_in = '0;
            end else begin
                rad_in  = r_rad[k-1];
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
            end
            cur       = {rem_in, rad_in[QB-1:QB-2]};
            trial     = {1'b0, root_in, 2'b01};
            take      = (cur >= trial);
            n_rem[k]  = take ? (RB+1)'(cur - trial) : cur[RB:0];
            n_root[k] = {root_in[RB-2:0], take};
            n_rad[k]  = {rad_in[QB-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RB; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule

### design/segment_point_geometry_unit.sv
// ============================================================================
// segment_point_geometry_unit - side test, point-line distance, intersection
// Pipeline: front end, then the one-bit-per-stage divider and root chains, then
//   the result register.
// Throughput: one item per cycle; the whole pipeline holds only while the
//   two-entry output buffer is full.
// Reset: i_rst_n synchronous, active low; clears all valid bits, no items held.
// ============================================================================
module segment_point_geometry_unit import spg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_mode,
    input  logic signed [CW-1:0] i_seg_a_x,
    input  logic signed [CW-1:0] i_seg_a_y,
    input  logic signed [CW-1:0] i_seg_b_x,
    input  logic signed [CW-1:0] i_seg_b_y,
    input  logic signed [CW-1:0] i_pt_x,
    input  logic signed [CW-1:0] i_pt_y,
    input  logic signed [CW-1:0] i_pt2_x,
    input  logic signed [CW-1:0] i_pt2_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [1:0]    o_side,
    output logic [RB-1:0]        o_distance_q8,
    output logic                 o_hit,
    output logic signed [XB-1:0] o_cross_x_q8,
    output logic signed [XB-1:0] o_cross_y_q8
);

    logic          en;
    logic          front_v;
    t_front        front;
    logic [QB-1:0] quo0, quo1;
    logic [RB-1:0] root;

    logic [SBD-1:0] r_vd;
    t_side          r_sb  [SBD];
    logic [XB-1:0]  r_q0d [RB];
    logic [XB-1:0]  r_q1d [RB];

    logic   r_ov, r_sv;
    t_res   r_out, r_skid;
    t_res   n_res;
    t_side  tail;
    logic   push, pop;

    // pipeline moves whenever the skid entry is free
    assign en      = !r_sv;
    assign o_ready = en;

    spg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_mode    (i_mode),
        .i_seg_a_x (i_seg_a_x),
        .i_seg_a_y (i_seg_a_y),
        .i_seg_b_x (i_seg_b_x),
        .i_seg_b_y (i_seg_b_y),
        .i_pt_x    (i_pt_x),
        .i_pt_y    (i_pt_y),
        .i_pt2_x   (i_pt2_x),
        .i_pt2_y   (i_pt2_y),
        .o_valid   (front_v),
        .o_front   (front)
    );

    // lane 0: distance or crossing x; lane 1: crossing y
    spg_div u_div0 (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (front.dvd0),
        .i_divisor  (front.dvs0),
        .o_quotient (quo0)
    );

    spg_div u_div1 (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (front.dvd1),
        .i_divisor  (front.dvs1),
        .o_quotient (quo1)
    );

    spg_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (quo0),
        .o_root     (root)
    );

    // valid bits alongside the divider and root stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (en) begin
            r_vd <= {r_vd[SBD-2:0], front_v};
        end
    end

    // control and crossing quotients delayed to line up with the root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= front.ctl;
            for (int k = 1; k < SBD; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_q0d[0] <= quo0[XB-1:0];
            r_q1d[0] <= quo1[XB-1:0];
            for (int k = 1; k < RB; k++) begin
                r_q0d[k] <= r_q0d[k-1];
                r_q1d[k] <= r_q1d[k-1];
            end
        end
    end

    // assemble the result item
    always_comb begin
        tail       = r_sb[SBD-1];
        n_res      = '0;
        n_res.side = tail.side;
        n_res.hit  = tail.hit;
        if (tail.mode == MODE_DIST) begin
            n_res.dist_q8 = root;
        end
        if (tail.hit) begin
            n_res.cx = tail.neg_x ? XB'(-r_q0d[RB-1]) : r_q0d[RB-1];
            n_res.cy = tail.neg_y ? XB'(-r_q1d[RB-1]) : r_q1d[RB-1];
        end
    end

    // two-entry output buffer
    assign push = en && r_vd[SBD-1];
    assign pop  = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (pop) begin
                if (r_sv) begin
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= push;
                end
            end else if (push) begin
                if (r_ov) begin
                    r_sv <= 1'b1;
                end else begin
                    r_ov <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_sv) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= n_res;
            end
        end else if (push) begin
            if (r_ov) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_side        = r_out.side;
    assign o_distance_q8 = r_out.dist_q8;
    assign o_hit         = r_out.hit;
    assign o_cross_x_q8  = r_out.cx;
    assign o_cross_y_q8  = r_out.cy;

endmodule

### design/spg_checker.sv
// ============================================================================
// spg_checker - port-level checks for the geometry unit
// Watches the result channel: held items and consistency between fields.
// ============================================================================
module spg_checker import spg_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic signed [1:0]    o_side,
    input logic [RB-1:0]        o_distance_q8,
    input logic                 o_hit,
    input logic signed [XB-1:0] o_cross_x_q8,
    input logic signed [XB-1:0] o_cross_y_q8
);

    // a stalled item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_side) &&
            $stable(o_distance_q8) && $stable(o_hit) &&
            $stable(o_cross_x_q8) && $stable(o_cross_y_q8))
        else $error("result item changed while stalled");

    // a miss carries no crossing point
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_cross_x_q8 == '0) && (o_cross_y_q8 == '0))
        else $error("crossing point on a miss");

    // side is never the unused code
    a_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_side != 2'b10)
        else $error("side out of range");

    // a side result carries nothing from the other modes
    a_side_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_side != 2'b00) |-> (o_distance_q8 == '0) && !o_hit)
        else $error("side item with other fields set");

    // a hit carries no distance
    a_hit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> (o_distance_q8 == '0) && (o_side == 2'b00))
        else $error("hit item with other fields set");

endmodule

bind segment_point_geometry_unit spg_checker u_spg_checker (.*);
